FILE: hw/rtl/dbs_pkg.sv
// Shared constants, codes and types of the DMA descriptor burst splitter.
// Used by dbs_seg_calc, the top level, the port checker and the testbench; no dependencies.
package dbs_pkg;

  // Line and burst sizes are powers of two, so block offsets are bit fields.
  localparam int unsigned LINE_BYTES  = 64;
  localparam int unsigned BURST_LINES = 4;
  localparam int unsigned BLOCK_BYTES = LINE_BYTES * BURST_LINES;
  localparam int unsigned LINE_W      = $clog2(LINE_BYTES);
  localparam int unsigned OFS_W       = $clog2(BLOCK_BYTES);

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 31;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned BURST_W = 3;

  localparam logic [BURST_W-1:0] BURST_ONE  = BURST_W'(1);
  localparam logic [BURST_W-1:0] BURST_FULL = BURST_W'(BURST_LINES);
  localparam logic [OFS_W:0]     BLOCK_LEN  = (OFS_W + 1)'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0]   BLOCK_CNT  = CNT_W'(BLOCK_BYTES);

  localparam logic [DIR_W-1:0] DIR_M2M = 2'd0;
  localparam logic [DIR_W-1:0] DIR_H2D = 2'd1;
  localparam logic [DIR_W-1:0] DIR_D2H = 2'd2;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_M2M,
    KIND_HOST
  } kind_t;

  // Request being split: addresses and count advance as descriptors leave.
  typedef struct packed {
    kind_t             kind;
    logic              host_is_src;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [CNT_W-1:0]  cnt;
    logic              early;
    logic              irq;
  } work_t;

  typedef struct packed {
    logic               status;
    logic [ADDR_W-1:0]  rd;
    logic [ADDR_W-1:0]  wr;
    logic [CNT_W-1:0]   len;
    logic [BURST_W-1:0] burst;
    logic               irq;
    logic               early;
    logic               last;
  } desc_t;

endpackage

FILE: hw/rtl/dbs_seg_calc.sv
// Cuts the next descriptor off the request in progress and gives the request
// that remains. Purely combinational; depends on dbs_pkg.
module dbs_seg_calc (
  input  dbs_pkg::work_t work_i,
  output dbs_pkg::desc_t desc_o,
  output dbs_pkg::work_t work_o
);
  import dbs_pkg::*;

  logic [ADDR_W-1:0]  host;
  logic [OFS_W-1:0]   off;
  logic [CNT_W-1:0]   room;
  logic [CNT_W-1:0]   seg;
  logic [CNT_W-1:0]   rem;
  logic [BURST_W-1:0] burst;

  assign host = work_i.host_is_src ? work_i.src : work_i.dst;
  assign off  = host[OFS_W-1:0];
  assign room = CNT_W'(BLOCK_LEN - {1'b0, off});

  // A misaligned host address gets a short head up to the next block
  // boundary; once aligned, whole blocks go as one burst and the rest as a tail.
  always_comb begin
    if (work_i.kind != KIND_HOST) begin
      seg   = work_i.cnt;
      burst = BURST_FULL;
    end else if (off != '0) begin
      seg   = (room >= work_i.cnt) ? work_i.cnt : room;
      burst = BURST_ONE;
    end else if (work_i.cnt >= BLOCK_CNT) begin
      seg   = {work_i.cnt[CNT_W-1:OFS_W], {OFS_W{1'b0}}};
      burst = BURST_FULL;
    end else begin
      seg   = work_i.cnt;
      burst = BURST_ONE;
    end
  end

  assign rem = work_i.cnt - seg;

  always_comb begin
    desc_o = '0;
    case (work_i.kind)
      KIND_ERR: begin
        desc_o.status = 1'b1;
        desc_o.last   = 1'b1;
      end
      KIND_M2M: begin
        desc_o.rd    = work_i.src;
        desc_o.wr    = work_i.dst;
        desc_o.len   = seg;
        desc_o.burst = burst;
        desc_o.irq   = work_i.irq;
        desc_o.early = work_i.early;
        desc_o.last  = 1'b1;
      end
      KIND_HOST: begin
        desc_o.rd    = work_i.src;
        desc_o.wr    = work_i.dst;
        desc_o.len   = seg;
        desc_o.burst = burst;
        desc_o.irq   = work_i.irq & (rem == '0);
        desc_o.early = work_i.early;
        desc_o.last  = (rem == '0);
      end
      default: begin
        desc_o.status = 1'b1;
        desc_o.last   = 1'b1;
      end
    endcase
  end

  always_comb begin
    work_o     = work_i;
    work_o.src = work_i.src + ADDR_W'(seg);
    work_o.dst = work_i.dst + ADDR_W'(seg);
    work_o.cnt = rem;
  end

endmodule

FILE: hw/rtl/dma_descriptor_burst_splitter_unit.sv
// Turns transfer requests into DMA descriptors. A request that is not line
// aligned gives one error beat; a memory-to-memory request gives one burst
// descriptor; a host-side request gives one to three descriptors (short head
// to the next block boundary of the host address, a body of whole blocks, a
// short tail), and none at all when its count is zero. Each descriptor goes
// out through the output register, so a request occupies the block until it
// has handed over all its descriptors, longer while the output stalls; a
// zero-count host request is absorbed in its acceptance cycle. The next
// request is taken in the cycle the current one hands over its last
// descriptor. Depends on dbs_pkg and dbs_seg_calc.
module dma_descriptor_burst_splitter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dbs_pkg::ADDR_W-1:0]    in_dest_address,
  input  logic [dbs_pkg::ADDR_W-1:0]    in_source_address,
  input  logic [dbs_pkg::CNT_W-1:0]     in_byte_count,
  input  logic [dbs_pkg::DIR_W-1:0]     in_direction,
  input  logic                          in_final_in_batch,
  input  logic                          in_want_interrupt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [dbs_pkg::ADDR_W-1:0]    out_read_address,
  output logic [dbs_pkg::ADDR_W-1:0]    out_write_address,
  output logic [dbs_pkg::CNT_W-1:0]     out_segment_length,
  output logic [dbs_pkg::BURST_W-1:0]   out_burst_lines,
  output logic                          out_irq_enable,
  output logic                          out_early_done,
  output logic                          out_last_of_run
);
  import dbs_pkg::*;

  logic  wk_valid_r, wk_valid_nxt;
  work_t wk_r, wk_nxt;
  work_t wk_adv;
  work_t in_work;
  desc_t desc;
  logic  out_valid_r, out_valid_nxt;
  desc_t out_r, out_nxt;

  logic in_fire;
  logic misaligned;
  logic skip;
  logic out_free;
  logic emit;

  dbs_seg_calc u_seg (
    .work_i (wk_r),
    .desc_o (desc),
    .work_o (wk_adv)
  );

  assign misaligned = (|in_dest_address[LINE_W-1:0]) | (|in_source_address[LINE_W-1:0]) |
                      (|in_byte_count[LINE_W-1:0]);

  always_comb begin
    in_work.src         = in_source_address;
    in_work.dst         = in_dest_address;
    in_work.cnt         = in_byte_count;
    in_work.host_is_src = (in_direction == DIR_H2D);
    in_work.early       = ~in_final_in_batch;
    in_work.irq         = in_want_interrupt;
    if (misaligned) begin
      in_work.kind = KIND_ERR;
    end else if (in_direction == DIR_M2M) begin
      in_work.kind = KIND_M2M;
    end else begin
      in_work.kind = KIND_HOST;
    end
  end

  // A host-side request of zero bytes produces nothing and never occupies the work register.
  assign skip     = (in_work.kind == KIND_HOST) && (in_byte_count == '0);
  assign out_free = ~out_valid_r | out_ready;
  assign emit     = wk_valid_r & out_free;
  assign in_ready = ~wk_valid_r | (out_free & desc.last);
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    wk_valid_nxt = wk_valid_r;
    wk_nxt       = wk_r;
    if (in_fire) begin
      wk_valid_nxt = ~skip;
      wk_nxt       = in_work;
    end else if (emit) begin
      wk_valid_nxt = ~desc.last;
      wk_nxt       = wk_adv;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wk_valid_r  <= wk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r  <= wk_nxt;
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_read_address   = out_r.rd;
  assign out_write_address  = out_r.wr;
  assign out_segment_length = out_r.len;
  assign out_burst_lines    = out_r.burst;
  assign out_irq_enable     = out_r.irq;
  assign out_early_done     = out_r.early;
  assign out_last_of_run    = out_r.last;

endmodule

FILE: hw/rtl/dbs_checker.sv
// Port-level checks on the descriptor splitter's result channel, bound to
// the top level. Depends on dbs_pkg.
module dbs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_status,
  input logic [dbs_pkg::ADDR_W-1:0]    out_read_address,
  input logic [dbs_pkg::ADDR_W-1:0]    out_write_address,
  input logic [dbs_pkg::CNT_W-1:0]     out_segment_length,
  input logic [dbs_pkg::BURST_W-1:0]   out_burst_lines,
  input logic                          out_irq_enable,
  input logic                          out_early_done,
  input logic                          out_last_of_run
);
  import dbs_pkg::*;

  // A stalled beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_address) &&
    $stable(out_write_address) && $stable(out_segment_length) && $stable(out_last_of_run))
    else $error("result beat changed while stalled");

  // An error beat closes its request and carries no descriptor.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_of_run && out_segment_length == '0 &&
    out_read_address == '0 && out_write_address == '0 && !out_irq_enable && !out_early_done)
    else $error("error beat with descriptor content");

  // The interrupt may only sit on the closing descriptor of a request.
  a_irq_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_enable |-> out_last_of_run)
    else $error("interrupt on a descriptor that does not close its request");

  // Descriptors only ever use a single-line or a full burst.
  a_burst_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_burst_lines == BURST_ONE || out_burst_lines == BURST_FULL)
    else $error("descriptor with an unexpected burst count");

endmodule

bind dma_descriptor_burst_splitter_unit dbs_checker u_dbs_checker (.*);

FILE: tb/dbs_descriptor_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the descriptor burst splitter, predicts each descriptor beat
// from the accepted request and compares it field by field. Depends on dbs_pkg.
module dbs_descriptor_checker
  import dbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [ADDR_W-1:0]  in_dest_address,
  input  logic [ADDR_W-1:0]  in_source_address,
  input  logic [CNT_W-1:0]   in_byte_count,
  input  logic [DIR_W-1:0]   in_direction,
  input  logic               in_final_in_batch,
  input  logic               in_want_interrupt,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_status,
  input  logic [ADDR_W-1:0]  out_read_address,
  input  logic [ADDR_W-1:0]  out_write_address,
  input  logic [CNT_W-1:0]   out_segment_length,
  input  logic [BURST_W-1:0] out_burst_lines,
  input  logic               out_irq_enable,
  input  logic               out_early_done,
  input  logic               out_last_of_run,
  output int                 mismatch_count,
  output int                 descs_pending,
  output int                 beats_checked,
  output int                 error_beats
);

  desc_t expected_descs[$];
  int    mismatch_total = 0;
  int    beat_total = 0;
  int    error_total = 0;

  assign mismatch_count = mismatch_total;
  assign descs_pending  = expected_descs.size();
  assign beats_checked  = beat_total;
  assign error_beats    = error_total;

  function automatic desc_t plain_desc(logic [ADDR_W-1:0] rd, logic [ADDR_W-1:0] wr,
                                       logic [63:0] len, logic [BURST_W-1:0] burst,
                                       logic early);
    desc_t d;
    d = '0;
    d.rd = rd;
    d.wr = wr;
    d.len = len[CNT_W-1:0];
    d.burst = burst;
    d.early = early;
    return d;
  endfunction

  // Splits one request into its descriptors and queues them in order.
  function automatic void split_request(logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src,
                                        logic [CNT_W-1:0] cnt, logic [DIR_W-1:0] dir,
                                        logic fin, logic irq);
    desc_t       run[3];
    desc_t       d;
    int          n;
    logic [63:0] host;
    logic [63:0] rd;
    logic [63:0] wr;
    logic [63:0] left;
    logic [63:0] seg;
    logic        early;
    n = 0;
    early = ~fin;
    if (dst[LINE_W-1:0] != 0 || src[LINE_W-1:0] != 0 || cnt[LINE_W-1:0] != 0) begin
      d = '0;
      d.status = 1'b1;
      d.last = 1'b1;
      expected_descs.push_back(d);
      return;
    end
    if (dir == DIR_M2M) begin
      d = plain_desc(src, dst, 64'(cnt), BURST_FULL, early);
      d.irq = irq;
      d.last = 1'b1;
      expected_descs.push_back(d);
      return;
    end
    // The host side is the source for host-to-device, the destination otherwise.
    host = (dir == DIR_H2D) ? src : dst;
    rd = src;
    wr = dst;
    left = 64'(cnt);
    if (left != 0 && host[OFS_W-1:0] != 0) begin
      seg = 64'(BLOCK_BYTES) - 64'(host[OFS_W-1:0]);
      if (seg > left) seg = left;
      run[n] = plain_desc(rd, wr, seg, BURST_ONE, early);
      n++;
      rd += seg;
      wr += seg;
      left -= seg;
    end
    if (left >= 64'(BLOCK_BYTES)) begin
      seg = left - 64'(left[OFS_W-1:0]);
      run[n] = plain_desc(rd, wr, seg, BURST_FULL, early);
      n++;
      rd += seg;
      wr += seg;
      left -= seg;
    end
    if (left != 0) begin
      run[n] = plain_desc(rd, wr, left, BURST_ONE, early);
      n++;
    end
    if (n > 0) begin
      run[n-1].irq = irq;
      run[n-1].last = 1'b1;
    end
    for (int k = 0; k < n; k++) expected_descs.push_back(run[k]);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    desc_t want;
    if (rst_n) begin
      // The output beat always stems from an earlier request, so check before predicting.
      if (out_valid && out_ready) begin
        beat_total++;
        if (out_status) error_total++;
        if (expected_descs.size() == 0) begin
          mismatch_total++;
          $display("%0t: descriptor beat with nothing expected, actual rd %0h wr %0h len %0h",
                   $time, out_read_address, out_write_address, out_segment_length);
        end else begin
          want = expected_descs.pop_front();
          compare_field("status", 64'(want.status), 64'(out_status));
          compare_field("read_address", want.rd, out_read_address);
          compare_field("write_address", want.wr, out_write_address);
          compare_field("segment_length", 64'(want.len), 64'(out_segment_length));
          compare_field("burst_lines", 64'(want.burst), 64'(out_burst_lines));
          compare_field("irq_enable", 64'(want.irq), 64'(out_irq_enable));
          compare_field("early_done", 64'(want.early), 64'(out_early_done));
          compare_field("last_of_run", 64'(want.last), 64'(out_last_of_run));
        end
      end
      if (in_valid && in_ready)
        split_request(in_dest_address, in_source_address, in_byte_count, in_direction,
                      in_final_in_batch, in_want_interrupt);
    end
  end

endmodule

FILE: tb/dma_descriptor_burst_splitter_unit_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the DMA descriptor burst splitter: directed requests, then
// random bursts with gaps and receiver stalls. Depends on dbs_pkg and dbs_descriptor_checker.
module dma_descriptor_burst_splitter_unit_test;
  import dbs_pkg::*;

  localparam logic [DIR_W-1:0] DIR_SPARE    = 2'd3;
  localparam int               RANDOM_ITEMS = 340;
  localparam int               HOLD_CYCLES  = 300;
  localparam int               STALL_LIMIT  = 3000;
  localparam int               DRAIN_CYCLES = 12;

  typedef struct {
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic [CNT_W-1:0]  cnt;
    logic [DIR_W-1:0]  dir;
    logic              fin;
    logic              irq;
  } request_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ADDR_W-1:0]  in_dest_address = '0;
  logic [ADDR_W-1:0]  in_source_address = '0;
  logic [CNT_W-1:0]   in_byte_count = '0;
  logic [DIR_W-1:0]   in_direction = DIR_M2M;
  logic               in_final_in_batch = 1'b0;
  logic               in_want_interrupt = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status;
  logic [ADDR_W-1:0]  out_read_address;
  logic [ADDR_W-1:0]  out_write_address;
  logic [CNT_W-1:0]   out_segment_length;
  logic [BURST_W-1:0] out_burst_lines;
  logic               out_irq_enable;
  logic               out_early_done;
  logic               out_last_of_run;

  int mismatch_count;
  int descs_pending;
  int beats_checked;
  int error_beats;
  int requests_sent = 0;
  int directed_sent = 0;
  bit pressure_on = 1'b0;

  always #10 clk = ~clk;

  dma_descriptor_burst_splitter_unit DUT (.*);

  dbs_descriptor_checker u_desc_check (.*);

  function automatic request_t mk(logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src,
                                  logic [CNT_W-1:0] cnt, logic [DIR_W-1:0] dir,
                                  logic fin, logic irq);
    request_t r;
    r.dst = dst;
    r.src = src;
    r.cnt = cnt;
    r.dir = dir;
    r.fin = fin;
    r.irq = irq;
    return r;
  endfunction

  // Mostly well-formed host requests of a few lines, with some memory-to-memory,
  // misaligned, spare-direction and very long requests mixed in.
  function automatic request_t random_request();
    request_t    r;
    int          pick;
    int          lines;
    logic [63:0] line_mask;
    line_mask = ~64'(LINE_BYTES - 1);
    pick = $urandom_range(0, 99);
    r.dst = {$urandom, $urandom} & line_mask;
    r.src = {$urandom, $urandom} & line_mask;
    r.fin = 1'($urandom_range(0, 1));
    r.irq = 1'($urandom_range(0, 1));
    r.dir = $urandom_range(0, 1) ? DIR_H2D : DIR_D2H;
    if ($urandom_range(0, 9) == 0) r.dir = DIR_SPARE;
    if (pick < 15) r.dir = DIR_M2M;
    if ($urandom_range(0, 19) == 0) begin
      r.cnt = CNT_W'($urandom) & ~CNT_W'(LINE_BYTES - 1);
    end else begin
      lines = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 20);
      r.cnt = CNT_W'(lines * LINE_BYTES);
    end
    if (pick >= 90) begin
      case ($urandom_range(0, 2))
        0: r.dst[LINE_W-1:0] = LINE_W'($urandom_range(1, LINE_BYTES - 1));
        1: r.src[LINE_W-1:0] = LINE_W'($urandom_range(1, LINE_BYTES - 1));
        default: r.cnt[LINE_W-1:0] = LINE_W'($urandom_range(1, LINE_BYTES - 1));
      endcase
    end
    return r;
  endfunction

  // Leaves valid high; the caller lowers it only when a gap follows.
  task automatic send_request(input request_t r);
    in_valid <= 1'b1;
    in_dest_address <= r.dst;
    in_source_address <= r.src;
    in_byte_count <= r.cnt;
    in_direction <= r.dir;
    in_final_in_batch <= r.fin;
    in_want_interrupt <= r.irq;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Receiver: a stall pattern that changes every so often, and one long hold-off.
  initial begin : receiver
    int   cyc;
    int   mode;
    bit   pressure_done;
    logic rdy;
    cyc = 0;
    mode = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on && !pressure_done) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      cyc++;
      if (cyc % 80 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (cyc % 5 != 0);
      endcase
      out_ready <= rdy;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("dma_descriptor_burst_splitter_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int burst;
    int gap;
    int sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Memory-to-memory extremes, then each misalignment on its own and all at once.
    send_request(mk('0, '0, '0, DIR_M2M, 1'b0, 1'b0));
    send_request(mk(64'hFFFF_FFFF_FFFF_FFC0, 64'hFFFF_FFFF_FFFF_FFC0, 31'h7FFF_FFC0,
                    DIR_M2M, 1'b1, 1'b1));
    send_request(mk(64'h1, '0, 31'd64, DIR_M2M, 1'b0, 1'b1));
    send_request(mk('0, 64'h20, 31'd64, DIR_H2D, 1'b1, 1'b0));
    send_request(mk('0, '0, 31'h7FFF_FFFF, DIR_D2H, 1'b0, 1'b0));
    send_request(mk('1, '1, '1, DIR_SPARE, 1'b1, 1'b1));
    // Host side: zero count gives nothing; block-aligned bodies and tails.
    send_request(mk(64'h1000, 64'h2000, '0, DIR_H2D, 1'b0, 1'b1));
    send_request(mk(64'h1000, 64'h2000, 31'd768, DIR_H2D, 1'b1, 1'b1));
    send_request(mk(64'h1000, 64'h2000, 31'd64, DIR_H2D, 1'b0, 1'b1));
    send_request(mk(64'h1000, 64'h2000, 31'd384, DIR_H2D, 1'b0, 1'b0));
    // Heads: short of the boundary, exactly to it, followed by a body ending on a
    // boundary (the interrupt must land on the body), and head, body and tail.
    send_request(mk(64'h1000, 64'h2040, 31'd64, DIR_H2D, 1'b1, 1'b1));
    send_request(mk(64'h1000, 64'h2040, 31'd192, DIR_H2D, 1'b1, 1'b1));
    send_request(mk(64'h1000, 64'h2040, 31'd704, DIR_H2D, 1'b0, 1'b1));
    send_request(mk(64'h1000, 64'h20C0, 31'd704, DIR_H2D, 1'b1, 1'b1));
    send_request(mk(64'h3080, 64'h4000, 31'd448, DIR_D2H, 1'b0, 1'b1));
    send_request(mk(64'h3040, 64'h4000, 31'd512, DIR_SPARE, 1'b1, 1'b1));
    // Address wrap-around and the largest aligned count.
    send_request(mk(64'h100, 64'hFFFF_FFFF_FFFF_FFC0, 31'd512, DIR_H2D, 1'b0, 1'b1));
    send_request(mk(64'hFFFF_FFFF_FFFF_FFC0, '0, 31'h7FFF_FFC0, DIR_D2H, 1'b1, 1'b1));
    send_request(mk(64'h5555_5555_5555_5540, 64'hAAAA_AAAA_AAAA_AA80, 31'h2AAA_AA80,
                    DIR_H2D, 1'b0, 1'b0));
    send_request(mk(64'h1000, 64'h2000, 31'h7FFF_FF00, DIR_M2M, 1'b0, 1'b0));
    directed_sent = requests_sent;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst; k++) begin
        send_request(random_request());
        sent++;
        if (sent == RANDOM_ITEMS / 3) pressure_on = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (descs_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d directed) and checked %0d descriptor beats,",
             requests_sent, directed_sent, beats_checked);
    $display("of which %0d were error beats, with a %0d-cycle output hold-off.",
             error_beats, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("dma_descriptor_burst_splitter_unit verification clean");
    end else begin
      $display("dma_descriptor_burst_splitter_unit verification failed");
    end
    $finish;
  end

endmodule
